// File: src/json_string_unescape_utf8_unit_macros.svh
// Assertion macros used by the checker file of the string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/jsu_pkg.sv
// Types and constants shared by the modules of the JSON string unescaper.
package jsu_pkg;

    typedef enum logic [2:0] {
        PH_OPEN,
        PH_PLAIN,
        PH_ESC,
        PH_HEX1,
        PH_HIGH,
        PH_HIGH_BS,
        PH_HEX2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CMD_RAW,
        CMD_CP,
        CMD_END,
        CMD_ERR
    } cmd_op_t;

    localparam int CP_W = 21;

    typedef struct packed {
        cmd_op_t         op;
        logic [CP_W-1:0] value;
    } cmd_t;

    localparam logic [2:0] ERR_ESC_UNFINISHED = 3'd0;
    localparam logic [2:0] ERR_BAD_HEX        = 3'd1;
    localparam logic [2:0] ERR_HEX_UNFINISHED = 3'd2;
    localparam logic [2:0] ERR_UNPAIRED_HIGH  = 3'd3;
    localparam logic [2:0] ERR_LONE_LOW       = 3'd4;

endpackage

// File: src/jsu_if.sv
// Valid/ready channel interfaces for token bytes and result bytes.
interface jsu_token_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink (input valid, input in_byte, input is_last, output ready);
    modport monitor (input valid, input in_byte, input is_last, input ready);
endinterface

interface jsu_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [2:0] error_code;
    logic       last_of_run;

    modport source (output valid, output out_kind, output out_byte, output error_code,
                    output last_of_run, input ready);
    modport sink (input valid, input out_kind, input out_byte, input error_code,
                  input last_of_run, output ready);
    modport monitor (input valid, input out_kind, input out_byte, input error_code,
                     input last_of_run, input ready);
endinterface

// File: src/jsu_front.sv
// Front end: escape-parsing state machine that turns each byte into at most one command.
module jsu_front
    import jsu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    jsu_token_if.sink     token,
    input  logic          cmd_full,
    output logic          cmd_push,
    output cmd_t          cmd
);

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [15:0] HIGH_MIN    = 16'hD800;
    localparam logic [15:0] HIGH_MAX    = 16'hDBFF;
    localparam logic [15:0] LOW_MIN     = 16'hDC00;
    localparam logic [15:0] LOW_MAX     = 16'hDFFF;
    localparam logic [31:0] JOIN_OFFSET = 32'h035FDC00;

    // Returns the bad-digit flag above the 4-bit digit value.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) r = {1'b0, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66) r = {1'b0, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46) r = {1'b0, 4'(b - 8'h37)};
        return r;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] first_unit_reg, first_unit_next;
    logic [15:0] hex_accum_reg, hex_accum_next;
    logic        skip_reg, skip_next;

    logic        accept;
    logic [4:0]  digit;
    logic        bad_digit;
    logic [15:0] unit;
    logic [31:0] joined;
    logic        unit_high;
    logic        unit_low;
    logic        cmd_valid;

    assign token.ready = !cmd_full;
    assign accept      = token.valid && token.ready;
    assign digit       = hex_digit(token.in_byte);
    assign bad_digit   = digit[4];
    assign unit        = {hex_accum_reg[11:0], digit[3:0]};
    assign joined      = ({16'b0, first_unit_reg} << 10) + {16'b0, unit} - JOIN_OFFSET;
    assign unit_high   = (unit >= HIGH_MIN) && (unit <= HIGH_MAX);
    assign unit_low    = (unit >= LOW_MIN) && (unit <= LOW_MAX);
    assign cmd_push    = accept && cmd_valid;

    always_comb
    begin
        phase_next      = phase_reg;
        hex_count_next  = hex_count_reg;
        first_unit_next = first_unit_reg;
        hex_accum_next  = hex_accum_reg;
        skip_next       = skip_reg;
        if (token.is_last)
        begin
            phase_next      = PH_OPEN;
            hex_count_next  = 2'd0;
            first_unit_next = 16'd0;
            hex_accum_next  = 16'd0;
            skip_next       = 1'b0;
        end
        else if (!skip_reg)
        begin
            unique case (phase_reg)
                PH_OPEN:
                begin
                    phase_next = PH_PLAIN;
                end
                PH_PLAIN:
                begin
                    if (token.in_byte == CH_BACKSLASH) phase_next = PH_ESC;
                end
                PH_ESC:
                begin
                    if (token.in_byte == CH_U)
                    begin
                        phase_next     = PH_HEX1;
                        hex_count_next = 2'd0;
                        hex_accum_next = 16'd0;
                    end
                    else
                    begin
                        phase_next = PH_PLAIN;
                    end
                end
                PH_HEX1, PH_HEX2:
                begin
                    if (bad_digit)
                    begin
                        skip_next = 1'b1;
                    end
                    else if (hex_count_reg != 2'd3)
                    begin
                        hex_count_next = hex_count_reg + 2'd1;
                        hex_accum_next = unit;
                    end
                    else
                    begin
                        hex_count_next = 2'd0;
                        hex_accum_next = 16'd0;
                        if (phase_reg == PH_HEX2)
                        begin
                            first_unit_next = 16'd0;
                            phase_next      = PH_PLAIN;
                        end
                        else if (unit_high)
                        begin
                            first_unit_next = unit;
                            phase_next      = PH_HIGH;
                        end
                        else if (unit_low)
                        begin
                            skip_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_PLAIN;
                        end
                    end
                end
                PH_HIGH:
                begin
                    if (token.in_byte != CH_BACKSLASH) skip_next = 1'b1;
                    else phase_next = PH_HIGH_BS;
                end
                PH_HIGH_BS:
                begin
                    if (token.in_byte != CH_U)
                    begin
                        skip_next = 1'b1;
                    end
                    else
                    begin
                        phase_next     = PH_HEX2;
                        hex_count_next = 2'd0;
                        hex_accum_next = 16'd0;
                    end
                end
                default:
                begin
                    phase_next = PH_OPEN;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd_valid = 1'b0;
        cmd.op    = CMD_RAW;
        cmd.value = {{(CP_W-8){1'b0}}, token.in_byte};
        if (!skip_reg)
        begin
            unique case (phase_reg)
                PH_OPEN:
                begin
                    if (token.is_last)
                    begin
                        cmd_valid = 1'b1;
                        cmd.op    = CMD_END;
                    end
                end
                PH_PLAIN:
                begin
                    if (token.is_last)
                    begin
                        cmd_valid = 1'b1;
                        cmd.op    = CMD_END;
                    end
                    else if (token.in_byte != CH_BACKSLASH)
                    begin
                        cmd_valid = 1'b1;
                    end
                end
                PH_ESC:
                begin
                    if (token.is_last)
                    begin
                        cmd_valid = 1'b1;
                        cmd.op    = CMD_ERR;
                        cmd.value = CP_W'(ERR_ESC_UNFINISHED);
                    end
                    else
                    begin
                        unique case (token.in_byte)
                            CH_B:
                            begin
                                cmd_valid = 1'b1;
                                cmd.value = CP_W'(8'h08);
                            end
                            CH_F:
                            begin
                                cmd_valid = 1'b1;
                                cmd.value = CP_W'(8'h0C);
                            end
                            CH_N:
                            begin
                                cmd_valid = 1'b1;
                                cmd.value = CP_W'(8'h0A);
                            end
                            CH_R:
                            begin
                                cmd_valid = 1'b1;
                                cmd.value = CP_W'(8'h0D);
                            end
                            CH_T:
                            begin
                                cmd_valid = 1'b1;
                                cmd.value = CP_W'(8'h09);
                            end
                            CH_QUOTE, CH_SLASH, CH_BACKSLASH:
                            begin
                                cmd_valid = 1'b1;
                            end
                            default:
                            begin
                                cmd_valid = 1'b0;
                            end
                        endcase
                    end
                end
                PH_HEX1, PH_HEX2:
                begin
                    if (token.is_last)
                    begin
                        cmd_valid = 1'b1;
                        cmd.op    = CMD_ERR;
                        if (phase_reg == PH_HEX2 && hex_count_reg == 2'd0)
                            cmd.value = CP_W'(ERR_UNPAIRED_HIGH);
                        else
                            cmd.value = CP_W'(ERR_HEX_UNFINISHED);
                    end
                    else if (bad_digit)
                    begin
                        cmd_valid = 1'b1;
                        cmd.op    = CMD_ERR;
                        cmd.value = CP_W'(ERR_BAD_HEX);
                    end
                    else if (hex_count_reg == 2'd3)
                    begin
                        if (phase_reg == PH_HEX2)
                        begin
                            cmd_valid = 1'b1;
                            cmd.op    = CMD_CP;
                            cmd.value = joined[CP_W-1:0];
                        end
                        else if (unit_low)
                        begin
                            cmd_valid = 1'b1;
                            cmd.op    = CMD_ERR;
                            cmd.value = CP_W'(ERR_LONE_LOW);
                        end
                        else if (!unit_high)
                        begin
                            cmd_valid = 1'b1;
                            cmd.op    = CMD_CP;
                            cmd.value = CP_W'(unit);
                        end
                    end
                end
                PH_HIGH:
                begin
                    if (token.is_last || token.in_byte != CH_BACKSLASH)
                    begin
                        cmd_valid = 1'b1;
                        cmd.op    = CMD_ERR;
                        cmd.value = CP_W'(ERR_UNPAIRED_HIGH);
                    end
                end
                PH_HIGH_BS:
                begin
                    if (token.is_last || token.in_byte != CH_U)
                    begin
                        cmd_valid = 1'b1;
                        cmd.op    = CMD_ERR;
                        cmd.value = CP_W'(ERR_UNPAIRED_HIGH);
                    end
                end
                default:
                begin
                    cmd_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_OPEN;
            hex_count_reg  <= 2'd0;
            first_unit_reg <= 16'd0;
            hex_accum_reg  <= 16'd0;
            skip_reg       <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            hex_count_reg  <= hex_count_next;
            first_unit_reg <= first_unit_next;
            hex_accum_reg  <= hex_accum_next;
            skip_reg       <= skip_next;
        end
    end

endmodule

// File: src/jsu_queue.sv
// Small register FIFO that holds commands between the parser and the encoder.
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    output logic head_valid,
    output cmd_t head,
    input  logic pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: src/jsu_back.sv
// Back end: expands each command into result bytes through a registered output stage.
module jsu_back
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  cmd_t        head,
    output logic        pop,
    jsu_result_if.source result
);

    localparam logic [CP_W-1:0] LIMIT_1 = CP_W'(32'h80);
    localparam logic [CP_W-1:0] LIMIT_2 = CP_W'(32'h800);
    localparam logic [CP_W-1:0] LIMIT_3 = CP_W'(32'h10000);
    localparam logic [7:0] LEAD_2 = 8'hC0;
    localparam logic [7:0] LEAD_3 = 8'hE0;
    localparam logic [7:0] LEAD_4 = 8'hF0;
    localparam logic [7:0] CONT   = 8'h80;

    logic [1:0]      idx_reg, idx_next;
    logic            valid_reg, valid_next;
    kind_t           kind_reg, kind_next;
    logic [7:0]      byte_reg, byte_next;
    logic [2:0]      code_reg, code_next;
    logic            last_reg, last_next;

    logic            load;
    logic [1:0]      n_m1;
    logic [1:0]      remaining;
    logic [CP_W-1:0] chunk;
    logic [7:0]      enc_byte;
    logic            final_byte;

    assign load       = head_valid && (!valid_reg || result.ready);
    assign remaining  = n_m1 - idx_reg;
    assign final_byte = (idx_reg == n_m1);
    assign pop        = load && final_byte;

    always_comb
    begin
        n_m1 = 2'd0;
        if (head.op == CMD_CP)
        begin
            if (head.value < LIMIT_1) n_m1 = 2'd0;
            else if (head.value < LIMIT_2) n_m1 = 2'd1;
            else if (head.value < LIMIT_3) n_m1 = 2'd2;
            else n_m1 = 2'd3;
        end
    end

    always_comb
    begin
        unique case (remaining)
            2'd0: chunk = head.value;
            2'd1: chunk = head.value >> 6;
            2'd2: chunk = head.value >> 12;
            default: chunk = head.value >> 18;
        endcase
        if (idx_reg != 2'd0)
        begin
            enc_byte = CONT | {2'b00, chunk[5:0]};
        end
        else
        begin
            unique case (n_m1)
                2'd0: enc_byte = chunk[7:0];
                2'd1: enc_byte = LEAD_2 | chunk[7:0];
                2'd2: enc_byte = LEAD_3 | chunk[7:0];
                default: enc_byte = LEAD_4 | chunk[7:0];
            endcase
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        code_next  = code_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            last_next  = final_byte;
            idx_next   = final_byte ? 2'd0 : idx_reg + 2'd1;
            code_next  = 3'd0;
            byte_next  = 8'd0;
            unique case (head.op)
                CMD_RAW:
                begin
                    kind_next = KIND_BYTE;
                    byte_next = head.value[7:0];
                end
                CMD_CP:
                begin
                    kind_next = KIND_BYTE;
                    byte_next = enc_byte;
                end
                CMD_END:
                begin
                    kind_next = KIND_END;
                end
                default:
                begin
                    kind_next = KIND_ERROR;
                    code_next = head.value[2:0];
                end
            endcase
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        code_reg <= code_next;
        last_reg <= last_next;
    end

    assign result.valid       = valid_reg;
    assign result.out_kind    = kind_reg;
    assign result.out_byte    = byte_reg;
    assign result.error_code  = code_reg;
    assign result.last_of_run = last_reg;

endmodule

// File: src/json_string_unescape_utf8_unit.sv
// Top level of the streaming JSON string unescaper with UTF-8 output.
//
//   Channel   Direction   Payload                                       Request
//   token     in          in_byte[7:0], is_last                         one token byte
//   result    out         out_kind[1:0], out_byte[7:0],                 one result item
//                         error_code[2:0], last_of_run
//
// The parser takes one byte per cycle while the command queue has room.
// A code point leaves as 1 to 4 result bytes, one per cycle while the result side is ready,
// from the encoder's output register; every other command gives one result.
// An accepted byte's command passes through the queue, then the output register, before its first result.
// Reset clears the parser, the queue and the output stage; no clearing pass is needed.
// A stalled result side fills the queue of QUEUE_DEPTH commands, then holds token ready low.
module json_string_unescape_utf8_unit
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    jsu_token_if.sink    token,
    jsu_result_if.source result
);

    logic cmd_push;
    cmd_t cmd;
    logic cmd_full;
    logic head_valid;
    cmd_t head;
    logic pop;

    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .token    (token),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd      (cmd)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_data  (cmd),
        .full       (cmd_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .result     (result)
    );

endmodule

// File: src/jsu_checker.sv
// Port-level checker for the string unescaper and its bind to the top level.
`include "json_string_unescape_utf8_unit_macros.svh"

module jsu_checker
    import jsu_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] out_kind,
    input logic [7:0] out_byte,
    input logic [2:0] error_code,
    input logic       last_of_run
);

    logic        end_seen;
    logic        error_seen;
    logic        other_seen;
    logic        end_clean;
    logic        error_clean;
    logic        stalled;
    logic [13:0] res_bits;

    assign end_seen    = res_valid && (out_kind == KIND_END);
    assign error_seen  = res_valid && (out_kind == KIND_ERROR);
    assign other_seen  = res_valid && (out_kind != KIND_ERROR);
    assign end_clean   = last_of_run && (out_byte == 8'd0) && (error_code == 3'd0);
    assign error_clean = last_of_run && (out_byte == 8'd0);
    assign stalled     = res_valid && !res_ready;
    assign res_bits    = {out_kind, out_byte, error_code, last_of_run};

    `JSU_ASSERT_NOW(a_end_closes_run, clk, rst_n, end_seen, end_clean, "End must close its run.")
    `JSU_ASSERT_NOW(a_error_closes_run, clk, rst_n, error_seen, error_clean, "Error must close its run.")
    `JSU_ASSERT_NOW(a_code_only_on_error, clk, rst_n, other_seen, error_code == 3'd0, "Code only on error.")
    `JSU_ASSERT_NEXT(a_stall_holds, clk, rst_n, stalled, res_valid && $stable(res_bits), "Stall must hold.")

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .out_kind    (result.out_kind),
    .out_byte    (result.out_byte),
    .error_code  (result.error_code),
    .last_of_run (result.last_of_run)
);
